// ----- rtl/core/tkis_pkg.sv -----
// Package for the top-k index select core: shared constants and types.
package tkis_pkg;

  localparam int unsigned TkisKMax       = 64;
  localparam int unsigned TkisRowMax     = 65536;
  localparam int unsigned TkisValueWidth = 32;
  localparam int unsigned TkisCountWidth = 7;
  localparam int unsigned TkisIndexWidth = 16;
  localparam int unsigned TkisQueueDepth = 4;

  localparam logic [TkisCountWidth-1:0] TkisTopCountRst = TkisCountWidth'(1);

  typedef struct packed {
    logic empty;
    logic full;
  } tkis_q_stat_t;

endpackage

// ----- rtl/core/tkis_front.sv -----
// Front end: takes input beats, tags each with its row position, feeds the queue.
module tkis_front import tkis_pkg::*; #(
  parameter int unsigned ROW_MAX     = TkisRowMax,
  parameter int unsigned VALUE_WIDTH = TkisValueWidth,
  localparam int unsigned PosWidth   = $clog2(ROW_MAX)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic                   last_in_row_i,
  input  tkis_q_stat_t           q_stat_i,
  output logic                   q_wr_o,
  output logic [VALUE_WIDTH-1:0] q_value_o,
  output logic [PosWidth-1:0]    q_pos_o,
  output logic                   q_last_o
);

  logic [PosWidth-1:0] pos_q, pos_d;
  logic                accept;

  assign accept    = push_i && !q_stat_i.full;
  assign q_wr_o    = accept;
  assign q_value_o = value_i;
  assign q_pos_o   = pos_q;
  assign q_last_o  = last_in_row_i;

  // position saturates at the top index on overlong rows
  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      if (last_in_row_i) begin
        pos_d = '0;
      end else if (pos_q != PosWidth'(ROW_MAX - 1)) begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

// ----- rtl/core/tkis_queue.sv -----
// Short first-word-fall-through queue between front and back end.
module tkis_queue import tkis_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  localparam int unsigned PtrWidth = $clog2(TkisQueueDepth),
  localparam int unsigned CntWidth = $clog2(TkisQueueDepth + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_i,
  output logic [WIDTH-1:0] rd_data_o,
  output tkis_q_stat_t     stat_o
);

  logic [WIDTH-1:0]    mem_q [TkisQueueDepth];
  logic [PtrWidth-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntWidth-1:0] cnt_q;
  logic                do_wr, do_rd;

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == CntWidth'(TkisQueueDepth));
  assign do_wr        = wr_i && !stat_o.full;
  assign do_rd        = rd_i && !stat_o.empty;
  assign rd_data_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrWidth'(TkisQueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrWidth'(TkisQueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/tkis_list.sv -----
// Back end: sorted insertion list of cells, drained through an output register.
module tkis_list import tkis_pkg::*; #(
  parameter int unsigned K_MAX       = TkisKMax,
  parameter int unsigned ROW_MAX     = TkisRowMax,
  parameter int unsigned VALUE_WIDTH = TkisValueWidth,
  localparam int unsigned PosWidth   = $clog2(ROW_MAX),
  localparam int unsigned CntWidth   = $clog2(K_MAX + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [TkisCountWidth-1:0]   top_count_i,
  input  tkis_q_stat_t                q_stat_i,
  input  logic signed [VALUE_WIDTH-1:0] q_value_i,
  input  logic [PosWidth-1:0]         q_pos_i,
  input  logic                        q_last_i,
  output logic                        q_rd_o,
  input  logic                        pop_i,
  output logic                        empty_o,
  output logic [TkisIndexWidth-1:0]   element_index_o,
  output logic                        last_of_run_o
);

  typedef enum logic {
    StInsert,
    StDrain
  } state_e;

  state_e                        state_q;
  logic [CntWidth-1:0]           fill_q, fill_new, remain_q, k_clamp, n_emit;
  logic [TkisCountWidth-1:0]     k_sat;
  logic                          out_valid_q, out_last_q;
  logic [TkisIndexWidth-1:0]     out_idx_q;
  logic signed [VALUE_WIDTH-1:0] val_q [K_MAX];
  logic [PosWidth-1:0]           pos_q [K_MAX];
  logic [K_MAX-1:0]              beats;
  logic                          ins_go, load_out;

  assign ins_go   = (state_q == StInsert) && !q_stat_i.empty;
  assign q_rd_o   = ins_go;
  assign load_out = (state_q == StDrain) && (!out_valid_q || pop_i);

  assign fill_new = (fill_q == CntWidth'(K_MAX)) ? fill_q : fill_q + 1'b1;

  always_comb begin
    k_sat = top_count_i;
    if (top_count_i == '0) begin
      k_sat = TkisCountWidth'(1);
    end else if (top_count_i > TkisCountWidth'(K_MAX)) begin
      k_sat = TkisCountWidth'(K_MAX);
    end
  end
  assign k_clamp = CntWidth'(k_sat);
  assign n_emit  = (k_clamp < fill_new) ? k_clamp : fill_new;

  // Each cell compares the incoming entry against its own; the beat vector is
  // a thermometer since the list is sorted, so the first set bit is the slot.
  for (genvar i = 0; i < K_MAX; i++) begin : g_cell
    assign beats[i] = (CntWidth'(i) >= fill_q) || (q_value_i > val_q[i]) ||
                      ((q_value_i == val_q[i]) && (q_pos_i < pos_q[i]));

    if (i == 0) begin : g_head
      always_ff @(posedge clk_i) begin
        if (ins_go && beats[i]) begin
          val_q[i] <= q_value_i;
          pos_q[i] <= q_pos_i;
        end else if (load_out && (K_MAX > 1)) begin
          val_q[i] <= val_q[(K_MAX > 1) ? 1 : 0];
          pos_q[i] <= pos_q[(K_MAX > 1) ? 1 : 0];
        end
      end
    end else begin : g_body
      always_ff @(posedge clk_i) begin
        if (ins_go) begin
          if (beats[i-1]) begin
            val_q[i] <= val_q[i-1];
            pos_q[i] <= pos_q[i-1];
          end else if (beats[i]) begin
            val_q[i] <= q_value_i;
            pos_q[i] <= q_pos_i;
          end
        end else if (load_out && (i < K_MAX - 1)) begin
          val_q[i] <= val_q[(i < K_MAX - 1) ? i + 1 : i];
          pos_q[i] <= pos_q[(i < K_MAX - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StInsert;
      fill_q      <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_idx_q   <= '0;
    end else begin
      if (pop_i && out_valid_q && !load_out) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StInsert: begin
          if (ins_go) begin
            if (q_last_i) begin
              fill_q   <= fill_new;
              remain_q <= n_emit;
              state_q  <= StDrain;
            end else begin
              fill_q <= fill_new;
            end
          end
        end
        StDrain: begin
          if (load_out) begin
            out_valid_q <= 1'b1;
            out_idx_q   <= TkisIndexWidth'(pos_q[0]);
            out_last_q  <= (remain_q == CntWidth'(1));
            remain_q    <= remain_q - 1'b1;
            if (remain_q == CntWidth'(1)) begin
              fill_q  <= '0;
              state_q <= StInsert;
            end
          end
        end
        default: state_q <= StInsert;
      endcase
    end
  end

  assign empty_o         = !out_valid_q;
  assign element_index_o = out_idx_q;
  assign last_of_run_o   = out_last_q;

endmodule

// ----- rtl/core/top_k_index_select_core.sv -----
// Top level of the streaming top-k index select core.
//
//  Channel  | Handshake         | Beat contents
//  ---------+-------------------+-------------------------------------
//  input    | push_i / full_o   | value_i, last_in_row_i
//  result   | pop_i / empty_o   | element_index_o, last_of_run_o
//  config   | top_count_we_i    | top_count_i
//
// Insertion into the cell list takes a beat from the queue whenever it holds one,
// so rows stream at one beat per cycle outside a drain. A closing beat starts a
// drain of the row's results, paced by pop_i through the output register; the
// front keeps accepting into a 4-deep queue meanwhile. No clearing pass after
// reset. full_o rises only when the queue fills during a drain or a stall.
module top_k_index_select_core import tkis_pkg::*; #(
  parameter int unsigned K_MAX       = TkisKMax,
  parameter int unsigned ROW_MAX     = TkisRowMax,
  parameter int unsigned VALUE_WIDTH = TkisValueWidth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  output logic                      full_o,
  input  logic [VALUE_WIDTH-1:0]    value_i,
  input  logic                      last_in_row_i,
  output logic                      empty_o,
  input  logic                      pop_i,
  output logic [TkisIndexWidth-1:0] element_index_o,
  output logic                      last_of_run_o,
  input  logic                      top_count_we_i,
  input  logic [TkisCountWidth-1:0] top_count_i
);

  localparam int unsigned PosWidth = $clog2(ROW_MAX);
  localparam int unsigned QWidth   = VALUE_WIDTH + PosWidth + 1;

  logic [TkisCountWidth-1:0] top_count_q;
  tkis_q_stat_t              q_stat;
  logic                      q_wr, q_rd, q_last_w, q_last_r;
  logic [VALUE_WIDTH-1:0]    q_value_w, q_value_r;
  logic [PosWidth-1:0]       q_pos_w, q_pos_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_count_q <= TkisTopCountRst;
    end else if (top_count_we_i) begin
      top_count_q <= top_count_i;
    end
  end

  assign full_o = q_stat.full;

  tkis_front #(
    .ROW_MAX     (ROW_MAX),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push_i),
    .value_i       (value_i),
    .last_in_row_i (last_in_row_i),
    .q_stat_i      (q_stat),
    .q_wr_o        (q_wr),
    .q_value_o     (q_value_w),
    .q_pos_o       (q_pos_w),
    .q_last_o      (q_last_w)
  );

  tkis_queue #(
    .WIDTH (QWidth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_wr),
    .wr_data_i ({q_value_w, q_pos_w, q_last_w}),
    .rd_i      (q_rd),
    .rd_data_o ({q_value_r, q_pos_r, q_last_r}),
    .stat_o    (q_stat)
  );

  tkis_list #(
    .K_MAX       (K_MAX),
    .ROW_MAX     (ROW_MAX),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_list (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .top_count_i     (top_count_q),
    .q_stat_i        (q_stat),
    .q_value_i       ($signed(q_value_r)),
    .q_pos_i         (q_pos_r),
    .q_last_i        (q_last_r),
    .q_rd_o          (q_rd),
    .pop_i           (pop_i),
    .empty_o         (empty_o),
    .element_index_o (element_index_o),
    .last_of_run_o   (last_of_run_o)
  );

  a_queue_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty at once");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !full_o) |=> !q_stat.empty)
    else $error("accepted beat did not reach the queue");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (element_index_o <= TkisIndexWidth'(ROW_MAX - 1)))
    else $error("result index beyond row range");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(element_index_o)))
    else $error("waiting result changed before pop");

endmodule
